### hw/rtl/qrdp_pkg.sv
package qrdp_pkg;

    localparam int ACC_WIDTH_DEF = 48;
    localparam int OUT_WIDTH     = 48;
    localparam int DATA_WIDTH    = 16;
    localparam int FMT_WIDTH     = 2;

    localparam logic [FMT_WIDTH-1:0] FMT_FIXED = 2'd0;
    localparam logic [FMT_WIDTH-1:0] FMT_INT8  = 2'd1;
    localparam logic [FMT_WIDTH-1:0] FMT_INT4  = 2'd2;

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic pp_lo;
        logic pp_hi;
        logic sum;
        logic load_out;
    } qrdp_cmd_t;

    typedef struct packed {
        logic last;
        logic scaled;
    } qrdp_status_t;

endpackage

### hw/rtl/quantized_row_dot_product.sv
// Quantized row dot product: multiply-accumulate of one matrix row.
// Input channel (in_valid/in_ready): activation (Q3.12), weight_code and
// row_scale, with last_in_row marking the final element of a row.
// Output channel (out_valid/out_ready): dot_product, one item per row,
// issued for the item that carries last_in_row.
// Configuration: cfg_wr_en/cfg_wr_data write weight_format (fixed, int8,
// int4); write only while no row is in flight.
// One element in work at a time: accept, multiply and saturating accumulate
// run through the single controller sequence before the next is taken.
// After the last element of a row, fixed-point weights go straight to the
// output load; for scaled formats the scale product first takes two passes
// (low, high) through one 33x17 multiplier plus a register-to-register add.
// With a free output register the result is loaded and out_valid rises.
// Reset clears the accumulator, the format (to fixed-point) and out_valid.
// The output register holds a result while out_ready is low; the next
// element is still taken, and a later row result waits until the register
// frees up.
module quantized_row_dot_product #(
    parameter int ACC_WIDTH = qrdp_pkg::ACC_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [qrdp_pkg::FMT_WIDTH-1:0]         cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [qrdp_pkg::DATA_WIDTH-1:0] activation,
    input  logic signed [qrdp_pkg::DATA_WIDTH-1:0] weight_code,
    input  logic [qrdp_pkg::DATA_WIDTH-1:0]        row_scale,
    input  logic                                   last_in_row,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [qrdp_pkg::OUT_WIDTH-1:0]  dot_product
);

    qrdp_pkg::qrdp_cmd_t    cmd;
    qrdp_pkg::qrdp_status_t status;

    qrdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    qrdp_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .activation  (activation),
        .weight_code (weight_code),
        .row_scale   (row_scale),
        .last_in_row (last_in_row),
        .cmd         (cmd),
        .status      (status),
        .dot_product (dot_product)
    );

endmodule

### hw/rtl/qrdp_ctrl.sv
module qrdp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  qrdp_pkg::qrdp_status_t status,
    output qrdp_pkg::qrdp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_LO   = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (!status.last)
                    state_next = S_IDLE;
                else if (status.scaled)
                    state_next = S_LO;
                else
                    state_next = S_OUT;
            end
            S_LO:
            begin
                cmd.pp_lo  = 1'b1;
                state_next = S_HI;
            end
            S_HI:
            begin
                cmd.pp_hi  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/qrdp_datapath.sv
module qrdp_datapath #(
    parameter int ACC_WIDTH = qrdp_pkg::ACC_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [qrdp_pkg::FMT_WIDTH-1:0]         cfg_wr_data,
    input  logic signed [qrdp_pkg::DATA_WIDTH-1:0] activation,
    input  logic signed [qrdp_pkg::DATA_WIDTH-1:0] weight_code,
    input  logic [qrdp_pkg::DATA_WIDTH-1:0]        row_scale,
    input  logic                                   last_in_row,
    input  qrdp_pkg::qrdp_cmd_t                    cmd,
    output qrdp_pkg::qrdp_status_t                 status,
    output logic signed [qrdp_pkg::OUT_WIDTH-1:0]  dot_product
);

    localparam int DW    = qrdp_pkg::DATA_WIDTH;
    localparam int SUM_W = ACC_WIDTH + DW;
    localparam int HI_W  = ACC_WIDTH - 32;
    localparam int PH_W  = ACC_WIDTH - DW;

    logic [qrdp_pkg::FMT_WIDTH-1:0] fmt_reg;
    logic signed [DW-1:0]           act_reg;
    logic signed [DW-1:0]           w_reg;
    logic signed [DW-1:0]           w_next;
    logic [DW-1:0]                  scale_reg;
    logic                           last_reg;
    logic signed [2*DW-1:0]         prod_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg;
    logic signed [ACC_WIDTH-1:0]    acc_next;
    logic [ACC_WIDTH:0]             acc_sum;
    logic [47:0]                    pp_lo_reg;
    logic [PH_W-1:0]                pp_hi_reg;
    logic [SUM_W-1:0]               full_sum;
    logic signed [ACC_WIDTH-1:0]    sum_reg;
    logic signed [32:0]             mul_a;
    logic signed [DW:0]             mul_b;
    logic signed [DW+32:0]          mul_p;
    logic signed [ACC_WIDTH-1:0]    out_res;
    logic signed [63:0]             res_ext;
    logic signed [qrdp_pkg::OUT_WIDTH-1:0] dot_reg;

    always_comb
    begin
        case (fmt_reg)
            qrdp_pkg::FMT_FIXED: w_next = weight_code;
            qrdp_pkg::FMT_INT8:  w_next = {{(DW-8){weight_code[7]}}, weight_code[7:0]};
            default:             w_next = {{(DW-4){~weight_code[3]}}, ~weight_code[3],
                                           weight_code[2:0]};
        endcase
    end

    assign acc_sum = {acc_reg[ACC_WIDTH-1], acc_reg}
                   + {{(ACC_WIDTH-2*DW+1){prod_reg[2*DW-1]}}, prod_reg};

    always_comb
    begin
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
            acc_next = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        else
            acc_next = acc_sum[ACC_WIDTH-1:0];
    end

    // shared scale multiplier: low 32 bits unsigned, then signed upper part
    assign mul_a = cmd.pp_hi ? 33'(signed'(acc_reg[ACC_WIDTH-1:32]))
                             : {1'b0, acc_reg[31:0]};
    assign mul_b = {1'b0, scale_reg};
    assign mul_p = mul_a * mul_b;

    assign full_sum = {pp_hi_reg, 32'd0} + {{HI_W{1'b0}}, pp_lo_reg};

    assign out_res = status.scaled ? sum_reg : acc_reg;
    assign res_ext = 64'(out_res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= qrdp_pkg::FMT_FIXED;
            acc_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                fmt_reg <= cfg_wr_data;
            if (cmd.acc)
                acc_reg <= acc_next;
            else if (cmd.load_out)
                acc_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= activation;
            w_reg     <= w_next;
            scale_reg <= row_scale;
            last_reg  <= last_in_row;
        end
        if (cmd.mul)
            prod_reg <= act_reg * w_reg;
        if (cmd.pp_lo)
            pp_lo_reg <= mul_p[47:0];
        if (cmd.pp_hi)
            pp_hi_reg <= mul_p[PH_W-1:0];
        if (cmd.sum)
            sum_reg <= full_sum[SUM_W-1:DW];
        if (cmd.load_out)
            dot_reg <= res_ext[qrdp_pkg::OUT_WIDTH-1:0];
    end

    assign status.last   = last_reg;
    assign status.scaled = (fmt_reg != qrdp_pkg::FMT_FIXED);
    assign dot_product   = dot_reg;

endmodule

### hw/rtl/qrdp_checker.sv
module qrdp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [qrdp_pkg::OUT_WIDTH-1:0] dot_product
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dot_product))
        else $error("stalled result dropped or changed");

    // one element in flight: busy right after an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous still in work");

    // no result can appear in the cycle right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result issued too early");

    // a new result appears only while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result issued with no item in work");

endmodule

bind quantized_row_dot_product qrdp_checker u_qrdp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dot_product (dot_product)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DW = qrdp_pkg::DATA_WIDTH;
    localparam int FW = qrdp_pkg::FMT_WIDTH;
    localparam int OW = qrdp_pkg::OUT_WIDTH;
    localparam logic [FW-1:0] FMT_INT4_ALT = 2'd3;
    localparam longint ACC_MAX = (longint'(1) <<< (qrdp_pkg::ACC_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int     LONG_HOLD = 400;

    typedef struct {
        logic [DW-1:0] act;
        logic [DW-1:0] code;
        logic [DW-1:0] scale;
        logic          is_last;
    } elem_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [FW-1:0] cfg_wr_data = qrdp_pkg::FMT_FIXED;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [DW-1:0] activation = '0;
    logic signed [DW-1:0] weight_code = '0;
    logic [DW-1:0] row_scale = '0;
    logic last_in_row = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OW-1:0] dot_product;

    elem_t elem_q[$];
    logic signed [OW-1:0] row_sum_q[$];
    longint row_acc_model = 0;
    logic [FW-1:0] fmt_model = qrdp_pkg::FMT_FIXED;
    int pushed_cnt = 0;
    int taken_cnt = 0;
    int errors = 0;
    int gap_cnt = 0;
    int hold_cnt = 0;
    bit calm = 1'b0;
    bit long_req = 1'b0;
    bit long_done = 1'b0;

    quantized_row_dot_product dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .activation  (activation),
        .weight_code (weight_code),
        .row_scale   (row_scale),
        .last_in_row (last_in_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dot_product (dot_product)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void mac_element(input elem_t e);
        longint w;
        longint sum;
        longint res;
        case (fmt_model)
            qrdp_pkg::FMT_FIXED: w = longint'($signed(e.code));
            qrdp_pkg::FMT_INT8:  w = longint'($signed(e.code[7:0]));
            default:             w = longint'({1'b0, e.code[3:0]}) - 8;
        endcase
        sum = row_acc_model + longint'($signed(e.act)) * w;
        if (sum > ACC_MAX)
            sum = ACC_MAX;
        else if (sum < ACC_MIN)
            sum = ACC_MIN;
        row_acc_model = sum;
        if (e.is_last)
        begin
            if (fmt_model == qrdp_pkg::FMT_FIXED)
                res = row_acc_model;
            else
            begin
                res = (row_acc_model * longint'({48'd0, e.scale})) >>> 16;
                if (res > ACC_MAX)
                    res = ACC_MAX;
                else if (res < ACC_MIN)
                    res = ACC_MIN;
            end
            row_sum_q.push_back(res[OW-1:0]);
            row_acc_model = 0;
        end
    endfunction

    function automatic logic [DW-1:0] rand_field();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic [DW-1:0] act, input logic [DW-1:0] code,
                            input logic [DW-1:0] scale, input logic is_last);
        elem_t e;
        e.act = act;
        e.code = code;
        e.scale = scale;
        e.is_last = is_last;
        elem_q.push_back(e);
        pushed_cnt++;
    endtask

    task automatic add_random_rows(input int n_items, input int max_len);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, max_len * 4);
            else
                len = $urandom_range(1, max_len);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                add_item(rand_field(), rand_field(), rand_field(), k == len - 1);
            left -= len;
        end
    endtask

    // wait until every item is taken and every row sum has come back
    task automatic drain();
        do
            @(posedge clk);
        while (taken_cnt != pushed_cnt || row_sum_q.size() != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_format(input logic [FW-1:0] fmt);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= fmt;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        fmt_model = fmt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        elem_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_cnt <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                nxt.act = activation;
                nxt.code = weight_code;
                nxt.scale = row_scale;
                nxt.is_last = last_in_row;
                mac_element(nxt);
                taken_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_cnt != 0)
                begin
                    in_valid <= 1'b0;
                    gap_cnt <= gap_cnt - 1;
                end
                else if (elem_q.size() != 0)
                begin
                    nxt = elem_q.pop_front();
                    in_valid <= 1'b1;
                    activation <= nxt.act;
                    weight_code <= nxt.code;
                    row_scale <= nxt.scale;
                    last_in_row <= nxt.is_last;
                    if (!calm && $urandom_range(0, 9) == 0)
                        gap_cnt <= $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
            long_done <= 1'b0;
        end
        else if (long_req && !long_done)
        begin
            long_done <= 1'b1;
            hold_cnt <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            hold_cnt <= $urandom_range(0, 17);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_proc
        logic signed [OW-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (row_sum_q.size() == 0)
            begin
                if (errors < 40)
                    $display("%0t: dot_product expected none actual %0d", $time, dot_product);
                errors++;
            end
            else
            begin
                want = row_sum_q.pop_front();
                if (dot_product !== want)
                begin
                    if (errors < 40)
                        $display("%0t: dot_product expected %0d actual %0d",
                                 $time, want, dot_product);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        logic [FW-1:0] fmt_seq[8];
        fmt_seq = '{qrdp_pkg::FMT_INT8, qrdp_pkg::FMT_INT4, qrdp_pkg::FMT_FIXED,
                    FMT_INT4_ALT, qrdp_pkg::FMT_INT8, qrdp_pkg::FMT_FIXED,
                    qrdp_pkg::FMT_INT4, qrdp_pkg::FMT_INT8};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_format(qrdp_pkg::FMT_FIXED);
        add_item(16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
        add_item(16'h8000, 16'h8000, 16'hFFFF, 1'b0);
        add_item(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
        add_item(16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();

        set_format(qrdp_pkg::FMT_INT8);
        add_item(16'h7FFF, 16'h7F80, 16'hFFFF, 1'b0);
        add_item(16'h8000, 16'h807F, 16'hFFFF, 1'b1);
        add_item(16'h8000, 16'hFF80, 16'h0000, 1'b1);
        add_item(16'hFFFF, 16'h0001, 16'h0001, 1'b1);
        add_item(16'h0001, 16'h0001, 16'h0001, 1'b1);
        drain();

        set_format(qrdp_pkg::FMT_INT4);
        add_item(16'h7FFF, 16'hFFF0, 16'h1234, 1'b0);
        add_item(16'h8000, 16'h000F, 16'h0000, 1'b0);
        add_item(16'h8000, 16'h0000, 16'hFFFF, 1'b1);
        add_item(16'h3039, 16'h0008, 16'h8000, 1'b1);
        drain();

        set_format(FMT_INT4_ALT);
        add_item(16'h8000, 16'h0000, 16'hFFFF, 1'b1);
        add_item(16'h0064, 16'hABC3, 16'h1234, 1'b1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            set_format(fmt_seq[p]);
            if (p == 7)
                calm = 1'b1;
            if (p == 2)
            begin
                long_req = 1'b1;
                add_random_rows(170, 2);
            end
            else
                add_random_rows(170, 8);
            drain();
        end

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
